>>> src/utf8_visible_char_segmenter_top_assert.svh
// Assertion macros for the visible character segmenter.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef UTF8_VISIBLE_CHAR_SEGMENTER_TOP_ASSERT_SVH
`define UTF8_VISIBLE_CHAR_SEGMENTER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define UVS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define UVS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define UVS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define UVS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> src/uvs_pkg.sv
// Shared types and byte constants of the visible character segmenter.
// Depends on nothing.
package uvs_pkg;

	localparam int INDEX_WIDTH = 16;
	localparam int CODE_WIDTH  = 21;
	localparam int RESQ_DEPTH  = 4;

	// register indexes
	localparam logic REG_WINDOW_START  = 1'b0;
	localparam logic REG_WINDOW_LENGTH = 1'b1;

	localparam logic [7:0] NUL_BYTE   = 8'h00;
	localparam logic [7:0] MASK_TOP3  = 8'hE0;
	localparam logic [7:0] MASK_TOP4  = 8'hF0;
	localparam logic [7:0] MASK_TOP5  = 8'hF8;
	localparam logic [7:0] LEAD_2     = 8'hC0;
	localparam logic [7:0] LEAD_3     = 8'hE0;
	localparam logic [7:0] LEAD_4     = 8'hF0;
	localparam logic [7:0] PAY_2      = 8'h1F;
	localparam logic [7:0] PAY_3      = 8'h0F;
	localparam logic [7:0] PAY_4      = 8'h07;
	localparam logic [7:0] ESC_BYTE   = 8'h1B;
	localparam logic [7:0] CSI_OPEN   = 8'h5B;
	localparam logic [7:0] SEMI_BYTE  = 8'h3B;
	localparam logic [7:0] DIGIT_0    = 8'h30;
	localparam logic [7:0] DIGIT_9    = 8'h39;
	localparam logic [7:0] BYTES_MAX  = 8'hFF;

	typedef struct packed {
		logic [CODE_WIDTH-1:0]  code_point;
		logic [7:0]             unit_bytes;
		logic [INDEX_WIDTH-1:0] unit_index;
		logic                   in_window;
		logic                   is_end;
		logic                   truncated;
		logic                   last;
	} result_t;

	// results produced by one byte, in order; count is 0, 1 or 2
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

	typedef struct packed {
		logic                   en;
		logic                   index;
		logic [INDEX_WIDTH-1:0] data;
	} cfg_wr_t;

endpackage

>>> src/uvs_ifs.sv
// Channel interfaces: text bytes in, visible unit results out.
// Depends on nothing.
interface uvs_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	modport source(output valid, output text_byte, input ready);
	modport sink(input valid, input text_byte, output ready);
endinterface

interface uvs_unit_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic [7:0]  unit_bytes;
	logic [15:0] unit_index;
	logic        in_window;
	logic        is_end;
	logic        truncated;
	logic        last;
	modport source(output valid, output code_point, output unit_bytes, output unit_index,
		output in_window, output is_end, output truncated, output last, input ready);
	modport sink(input valid, input code_point, input unit_bytes, input unit_index,
		input in_window, input is_end, input truncated, input last, output ready);
endinterface

>>> src/utf8_visible_char_segmenter_top.sv
// Top level of the UTF-8 visible character segmenter with CSI grouping.
// Depends on uvs_pkg, uvs_ifs, uvs_core, uvs_resq and the assertion macro header.
//
//   channel    | dir | payload                                        | handshake
//   -----------+-----+------------------------------------------------+-------------
//   text_in    | in  | text_byte[7:0]                                 | valid/ready
//   unit_out   | out | code_point, unit_bytes, unit_index, in_window, | valid/ready
//              |     | is_end, truncated, last                        |
//   wr_*       | in  | wr_index (0 start, 1 length), wr_data[15:0]    | wr_en only
//
// Each byte is held in the input register, where the decode logic turns it into zero,
// one or two results that drop into a four-entry result queue. A byte is taken every cycle
// while the queue holds at most two results, so one result per byte runs at one byte a cycle;
// two-result bytes are bounded by the single output port. The input register and the queue lie
// between a byte and its first result. Reset clears decode state, counters and queue pointers;
// the window resets to start 0, length 65535. A stalled output backs up into the input register.
`include "utf8_visible_char_segmenter_top_assert.svh"
module utf8_visible_char_segmenter_top import uvs_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [15:0] wr_data,
	uvs_byte_if.sink    text_in,
	uvs_unit_if.source  unit_out
);

	cfg_wr_t cfg;
	push_t   push;
	logic    room;

	// bundle the register write request for the core
	assign cfg.en    = wr_en;
	assign cfg.index = wr_index;
	assign cfg.data  = wr_data;

	// decode: holds one byte request, the UTF-8/CSI state and the visible count
	uvs_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.text_in (text_in),
		.room    (room),
		.push    (push)
	);

	// queue: decouples the two-result bytes from the output handshake
	uvs_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.unit_out (unit_out)
	);

	// results only enter the queue when it has room for a full byte's worth
	`UVS_ASSERT_IMPL(a_push_room, clk, arst_n, push.count != 2'd0, room, "push without room")
	// a two-result byte marks only its second result as last
	`UVS_ASSERT_IMPL(a_pair_last, clk, arst_n, push.count == 2'd2, !push.r0.last && push.r1.last, "bad last on pair")
	// a single result is always last of its byte
	`UVS_ASSERT_IMPL(a_single_last, clk, arst_n, push.count == 2'd1, push.r0.last, "single not last")
	// truncation is reported only on the end result
	`UVS_ASSERT_IMPL(a_trunc_end, clk, arst_n, unit_out.valid && unit_out.truncated, unit_out.is_end, "truncated off end")

endmodule

>>> src/uvs_core.sv
// Byte input register, decode state and per-byte result logic.
// Depends on uvs_pkg and uvs_byte_if.
module uvs_core import uvs_pkg::*; #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_wr_t       cfg,
	uvs_byte_if.sink      text_in,
	input  logic          room,
	output push_t         push
);

	localparam int WW = ((COUNT_WIDTH > INDEX_WIDTH) ? COUNT_WIDTH : INDEX_WIDTH) + 1;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	typedef enum logic [1:0] {PH_IDLE, PH_CONT, PH_ESC, PH_CSI} phase_t;

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	phase_t                 phase_q, phase_n;
	logic [1:0]             left_q, left_n;
	logic [CODE_WIDTH-1:0]  acc_q, acc_n;
	logic [7:0]             ubc_q, ubc_n;
	logic [COUNT_WIDTH-1:0] vcnt_q, vcnt_n;
	logic [INDEX_WIDTH-1:0] win_start_q, win_len_q;

	logic                   advance;
	logic [COUNT_WIDTH-1:0] v1, v2;
	logic [7:0]             ubc_inc;
	logic [1:0]             lead_extra;
	logic [CODE_WIDTH-1:0]  lead_pl;
	logic [CODE_WIDTH-1:0]  acc_shift;
	logic [1:0]             left_dec;

	function automatic logic [INDEX_WIDTH-1:0] sat_idx(input logic [COUNT_WIDTH-1:0] v);
		logic [WW-1:0] vw;
		vw = WW'(v);
		sat_idx = (vw > WW'({INDEX_WIDTH{1'b1}})) ? {INDEX_WIDTH{1'b1}} : vw[INDEX_WIDTH-1:0];
	endfunction

	function automatic logic in_win(input logic [COUNT_WIDTH-1:0] v,
			input logic [INDEX_WIDTH-1:0] ws, input logic [INDEX_WIDTH-1:0] wl);
		logic [WW-1:0] vw;
		logic [WW-1:0] sw;
		vw = WW'(v);
		sw = WW'(ws);
		in_win = (vw >= sw) && ((vw - sw) < WW'(wl));
	endfunction

	function automatic result_t mk_unit(input logic [CODE_WIDTH-1:0] cp,
			input logic [7:0] nb, input logic [COUNT_WIDTH-1:0] v,
			input logic [INDEX_WIDTH-1:0] ws, input logic [INDEX_WIDTH-1:0] wl);
		result_t r;
		r.code_point = cp;
		r.unit_bytes = nb;
		r.unit_index = sat_idx(v);
		r.in_window  = in_win(v, ws, wl);
		r.is_end     = 1'b0;
		r.truncated  = 1'b0;
		r.last       = 1'b0;
		mk_unit = r;
	endfunction

	function automatic result_t mk_end(input logic [COUNT_WIDTH-1:0] v, input logic trunc);
		result_t r;
		r.code_point = '0;
		r.unit_bytes = '0;
		r.unit_index = sat_idx(v);
		r.in_window  = 1'b0;
		r.is_end     = 1'b1;
		r.truncated  = trunc;
		r.last       = 1'b1;
		mk_end = r;
	endfunction

	assign advance       = valid_s1 && room;
	assign text_in.ready = !valid_s1 || room;

	assign v1        = (vcnt_q == COUNT_MAX) ? vcnt_q : vcnt_q + COUNT_WIDTH'(1);
	assign v2        = (v1 == COUNT_MAX) ? v1 : v1 + COUNT_WIDTH'(1);
	assign ubc_inc   = (ubc_q == BYTES_MAX) ? ubc_q : ubc_q + 8'd1;
	assign acc_shift = {acc_q[CODE_WIDTH-7:0], byte_s1[5:0]};
	assign left_dec  = left_q - 2'd1;

	always_comb begin
		if ((byte_s1 & MASK_TOP3) == LEAD_2) begin
			lead_extra = 2'd1;
			lead_pl    = CODE_WIDTH'(byte_s1 & PAY_2);
		end else if ((byte_s1 & MASK_TOP4) == LEAD_3) begin
			lead_extra = 2'd2;
			lead_pl    = CODE_WIDTH'(byte_s1 & PAY_3);
		end else if ((byte_s1 & MASK_TOP5) == LEAD_4) begin
			lead_extra = 2'd3;
			lead_pl    = CODE_WIDTH'(byte_s1 & PAY_4);
		end else begin
			lead_extra = 2'd0;
			lead_pl    = CODE_WIDTH'(byte_s1);
		end
	end

	always_comb begin
		phase_n    = phase_q;
		left_n     = left_q;
		acc_n      = acc_q;
		ubc_n      = ubc_q;
		vcnt_n     = vcnt_q;
		push.count = 2'd0;
		push.r0    = '0;
		push.r1    = '0;

		if (byte_s1 == NUL_BYTE) begin
			if (ubc_q != 8'd0) begin
				push.count = 2'd2;
				push.r0    = mk_unit((phase_q == PH_ESC) ? CODE_WIDTH'(ESC_BYTE) : '0,
					ubc_q, vcnt_q, win_start_q, win_len_q);
				push.r1    = mk_end(v1, (phase_q == PH_CONT) ||
					(phase_q == PH_CSI && left_q != 2'd0));
			end else begin
				push.count = 2'd1;
				push.r0    = mk_end(vcnt_q, (phase_q == PH_CONT) ||
					(phase_q == PH_CSI && left_q != 2'd0));
			end
			phase_n = PH_IDLE;
			left_n  = '0;
			acc_n   = '0;
			ubc_n   = '0;
			vcnt_n  = '0;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (lead_extra != 2'd0) begin
						acc_n   = lead_pl;
						left_n  = lead_extra;
						phase_n = PH_CONT;
						ubc_n   = ubc_inc;
					end else if (byte_s1 == ESC_BYTE) begin
						phase_n = PH_ESC;
						ubc_n   = ubc_inc;
					end else begin
						push.count   = 2'd1;
						push.r0      = mk_unit(lead_pl, ubc_inc, vcnt_q, win_start_q, win_len_q);
						push.r0.last = 1'b1;
						ubc_n        = '0;
						vcnt_n       = v1;
						left_n       = '0;
					end
				end
				PH_CONT: begin
					acc_n = acc_shift;
					if (left_dec == 2'd0) begin
						push.count   = 2'd1;
						push.r0      = mk_unit(acc_shift, ubc_inc, vcnt_q, win_start_q, win_len_q);
						push.r0.last = 1'b1;
						ubc_n        = '0;
						vcnt_n       = v1;
						left_n       = '0;
						phase_n      = PH_IDLE;
					end else begin
						left_n = left_dec;
						ubc_n  = ubc_inc;
					end
				end
				PH_ESC: begin
					if (byte_s1 == CSI_OPEN) begin
						ubc_n   = ubc_inc;
						phase_n = PH_CSI;
						left_n  = '0;
					end else begin
						// the lone ESC is a unit of its own; the byte starts a new one
						push.r0 = mk_unit(CODE_WIDTH'(ESC_BYTE), ubc_q, vcnt_q,
							win_start_q, win_len_q);
						vcnt_n  = v1;
						ubc_n   = 8'd1;
						if (lead_extra != 2'd0) begin
							push.count   = 2'd1;
							push.r0.last = 1'b1;
							acc_n        = lead_pl;
							left_n       = lead_extra;
							phase_n      = PH_CONT;
						end else if (byte_s1 == ESC_BYTE) begin
							push.count   = 2'd1;
							push.r0.last = 1'b1;
							left_n       = '0;
							phase_n      = PH_ESC;
						end else begin
							push.count   = 2'd2;
							push.r1      = mk_unit(lead_pl, 8'd1, v1, win_start_q, win_len_q);
							push.r1.last = 1'b1;
							ubc_n        = '0;
							vcnt_n       = v2;
							left_n       = '0;
							phase_n      = PH_IDLE;
						end
					end
				end
				PH_CSI: begin
					ubc_n = ubc_inc;
					if (left_q != 2'd0) begin
						left_n = left_dec;
						if (left_dec == 2'd0) begin
							phase_n = PH_IDLE;
						end
					end else if (byte_s1 inside {SEMI_BYTE, [DIGIT_0:DIGIT_9]}) begin
						phase_n = PH_CSI;
					end else if (lead_extra != 2'd0) begin
						left_n = lead_extra;
					end else begin
						phase_n = PH_IDLE;
					end
				end
				default: begin
					phase_n = PH_IDLE;
				end
			endcase
		end

		if (!advance) begin
			push.count = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			phase_q     <= PH_IDLE;
			left_q      <= '0;
			acc_q       <= '0;
			ubc_q       <= '0;
			vcnt_q      <= '0;
			win_start_q <= '0;
			win_len_q   <= {INDEX_WIDTH{1'b1}};
		end else begin
			if (text_in.ready) begin
				valid_s1 <= text_in.valid;
			end
			if (advance) begin
				phase_q <= phase_n;
				left_q  <= left_n;
				acc_q   <= acc_n;
				ubc_q   <= ubc_n;
				vcnt_q  <= vcnt_n;
			end
			if (cfg.en) begin
				if (cfg.index == REG_WINDOW_START) begin
					win_start_q <= cfg.data;
				end else begin
					win_len_q <= cfg.data;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (text_in.ready && text_in.valid) begin
			byte_s1 <= text_in.text_byte;
		end
	end

endmodule

>>> src/uvs_resq.sv
// Result queue: takes up to two results a cycle, delivers one a cycle while the output is ready.
// Depends on uvs_pkg and uvs_unit_if.
module uvs_resq import uvs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  push_t       push,
	output logic        room,
	uvs_unit_if.source  unit_out
);

	localparam int PTR_W = $clog2(RESQ_DEPTH);
	localparam int CNT_W = $clog2(RESQ_DEPTH + 1);

	result_t            mem [RESQ_DEPTH];
	logic [PTR_W-1:0]   head_q, tail_q;
	logic [CNT_W-1:0]   count_q;
	logic               pop;
	result_t            head_r;

	assign pop    = unit_out.valid && unit_out.ready;
	assign room   = count_q <= CNT_W'(RESQ_DEPTH - 2);
	assign head_r = mem[head_q];

	assign unit_out.valid      = count_q != '0;
	assign unit_out.code_point = head_r.code_point;
	assign unit_out.unit_bytes = head_r.unit_bytes;
	assign unit_out.unit_index = head_r.unit_index;
	assign unit_out.in_window  = head_r.in_window;
	assign unit_out.is_end     = head_r.is_end;
	assign unit_out.truncated  = head_r.truncated;
	assign unit_out.last       = head_r.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + PTR_W'(push.count);
			head_q  <= head_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(push.count) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[tail_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem[tail_q + PTR_W'(1)] <= push.r1;
		end
	end

endmodule

>>> bench/tb_utf8_visible_char_segmenter_top.sv
// Self-checking bench for utf8_visible_char_segmenter_top: directed and random byte strings.
// Depends on uvs_pkg, the uvs_byte_if/uvs_unit_if interfaces and the segmenter RTL.
// An inline segmenter predictor computes the expected units checked at the output.
module tb_utf8_visible_char_segmenter_top;
	import uvs_pkg::*;

	localparam int QUIET_LIMIT     = 5000; // cycles with no request moving on either side
	localparam int DRAIN_CYCLES    = 8;    // covers the input register plus the queue
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int PHASE_ITEMS     = 190;
	localparam logic [7:0] CONT_MARK = 8'h80;
	localparam int CONT_BITS = 63;

	typedef enum logic [1:0] {SEG_IDLE, SEG_CONT, SEG_ESC, SEG_CSI} seg_phase_e;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        wr_en    = 1'b0;
	logic        wr_index = 1'b0;
	logic [15:0] wr_data  = 16'd0;

	uvs_byte_if byte_ch();
	uvs_unit_if unit_ch();

	utf8_visible_char_segmenter_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.text_in  (byte_ch),
		.unit_out (unit_ch)
	);

	always #5 clk = ~clk;

	// Predictor state: a private copy of the decoder state and the window registers.
	seg_phase_e  seg_phase;
	logic [1:0]  seg_left;
	logic [20:0] seg_code;
	logic [7:0]  seg_bytes;
	logic [15:0] seg_count;
	logic [15:0] win_start;
	logic [15:0] win_length;

	result_t step_results [2];
	int      step_count;
	result_t expected_units [$];

	logic [7:0] text_buf [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int bytes_sent    = 0;
	int error_count   = 0;
	int quiet_cycles  = 0;
	int stall_left    = 0;
	bit stall_request = 1'b0;

	function automatic logic [7:0] rand_byte(input int lo, input int hi);
		return 8'($urandom_range(hi, lo));
	endfunction

	function automatic void clear_segment_state();
		seg_phase = SEG_IDLE;
		seg_left  = 2'd0;
		seg_code  = 21'd0;
		seg_bytes = 8'd0;
		seg_count = 16'd0;
	endfunction

	// Count one byte into the pending unit; hold at the top.
	function automatic void count_byte();
		if (seg_bytes != BYTES_MAX)
			seg_bytes = seg_bytes + 8'd1;
	endfunction

	// Close the pending unit with the given code point and advance the visible index.
	function automatic void emit_unit(input logic [20:0] cp);
		result_t r;
		r.code_point = cp;
		r.unit_bytes = seg_bytes;
		r.unit_index = seg_count;
		r.in_window  = (seg_count >= win_start) && ((seg_count - win_start) < win_length);
		r.is_end     = 1'b0;
		r.truncated  = 1'b0;
		r.last       = 1'b0;
		step_results[step_count] = r;
		step_count = step_count + 1;
		seg_bytes = 8'd0;
		if (seg_count != 16'hFFFF)
			seg_count = seg_count + 16'd1;
		seg_phase = SEG_IDLE;
		seg_left  = 2'd0;
	endfunction

	// Sequence length from the lead byte; invalid leads and ASCII count as one byte.
	function automatic logic [2:0] lead_length(input logic [7:0] b, output logic [7:0] payload);
		if ((b & MASK_TOP3) == LEAD_2) begin
			payload = b & PAY_2;
			return 3'd2;
		end
		if ((b & MASK_TOP4) == LEAD_3) begin
			payload = b & PAY_3;
			return 3'd3;
		end
		if ((b & MASK_TOP5) == LEAD_4) begin
			payload = b & PAY_4;
			return 3'd4;
		end
		payload = b;
		return 3'd1;
	endfunction

	function automatic void start_char(input logic [7:0] b);
		logic [7:0] payload;
		logic [2:0] len;
		len = lead_length(b, payload);
		count_byte();
		if (len > 3'd1) begin
			seg_code  = {13'd0, payload};
			seg_left  = len[1:0] - 2'd1;
			seg_phase = SEG_CONT;
		end else if (b == ESC_BYTE) begin
			seg_phase = SEG_ESC;
		end else begin
			emit_unit({13'd0, b});
		end
	endfunction

	// Advance the predictor by one accepted byte and queue the units it closes.
	function automatic void segment_byte(input logic [7:0] b);
		logic       trunc;
		logic [7:0] payload;
		logic [2:0] len;
		result_t    fin;
		step_count = 0;
		if (b == NUL_BYTE) begin
			trunc = (seg_phase == SEG_CONT) || (seg_phase == SEG_CSI && seg_left != 2'd0);
			if (seg_bytes != 8'd0)
				emit_unit(seg_phase == SEG_ESC ? {13'd0, ESC_BYTE} : 21'd0);
			fin.code_point = 21'd0;
			fin.unit_bytes = 8'd0;
			fin.unit_index = seg_count;
			fin.in_window  = 1'b0;
			fin.is_end     = 1'b1;
			fin.truncated  = trunc;
			fin.last       = 1'b0;
			step_results[step_count] = fin;
			step_count = step_count + 1;
			clear_segment_state();
		end else begin
			case (seg_phase)
				SEG_IDLE: start_char(b);
				SEG_CONT: begin
					count_byte();
					seg_code = {seg_code[14:0], b[5:0]};
					seg_left = seg_left - 2'd1;
					if (seg_left == 2'd0)
						emit_unit(seg_code);
				end
				SEG_ESC: begin
					if (b == CSI_OPEN) begin
						count_byte();
						seg_phase = SEG_CSI;
						seg_left  = 2'd0;
					end else begin
						emit_unit({13'd0, ESC_BYTE});
						start_char(b);
					end
				end
				default: begin
					count_byte();
					if (seg_left != 2'd0) begin
						seg_left = seg_left - 2'd1;
						if (seg_left == 2'd0)
							seg_phase = SEG_IDLE;
					end else if (!(b == SEMI_BYTE || (b >= DIGIT_0 && b <= DIGIT_9))) begin
						// final character closes the sequence, possibly after its own tail
						len = lead_length(b, payload);
						if (len > 3'd1)
							seg_left = len[1:0] - 2'd1;
						else
							seg_phase = SEG_IDLE;
					end
				end
			endcase
		end
		if (step_count > 0)
			step_results[step_count-1].last = 1'b1;
		for (int i = 0; i < step_count; i++)
			expected_units.push_back(step_results[i]);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH: %s", msg);
		error_count = error_count + 1;
	endtask

	// Compare one accepted unit with the oldest expectation, field by field.
	task automatic check_unit();
		result_t want;
		if (expected_units.size() == 0) begin
			report_mismatch($sformatf("unexpected unit, index %0d end %0b",
				unit_ch.unit_index, unit_ch.is_end));
		end else begin
			want = expected_units.pop_front();
			if (unit_ch.code_point !== want.code_point)
				report_mismatch($sformatf("code_point %h, expected %h at index %0d",
					unit_ch.code_point, want.code_point, want.unit_index));
			if (unit_ch.unit_bytes !== want.unit_bytes)
				report_mismatch($sformatf("unit_bytes %0d, expected %0d at index %0d",
					unit_ch.unit_bytes, want.unit_bytes, want.unit_index));
			if (unit_ch.unit_index !== want.unit_index)
				report_mismatch($sformatf("unit_index %0d, expected %0d",
					unit_ch.unit_index, want.unit_index));
			if (unit_ch.in_window !== want.in_window)
				report_mismatch($sformatf("in_window %b, expected %b at index %0d",
					unit_ch.in_window, want.in_window, want.unit_index));
			if (unit_ch.is_end !== want.is_end)
				report_mismatch($sformatf("is_end %b, expected %b at index %0d",
					unit_ch.is_end, want.is_end, want.unit_index));
			if (unit_ch.truncated !== want.truncated)
				report_mismatch($sformatf("truncated %b, expected %b at index %0d",
					unit_ch.truncated, want.truncated, want.unit_index));
			if (unit_ch.last !== want.last)
				report_mismatch($sformatf("last %b, expected %b at index %0d",
					unit_ch.last, want.last, want.unit_index));
		end
	endtask

	// Monitor: sample both channels at the edge, predict first, then check.
	// The watchdog lives here too since it needs both handshakes.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1)
				segment_byte(byte_ch.text_byte);
			if (unit_ch.valid === 1'b1 && unit_ch.ready === 1'b1)
				check_unit();
			if ((byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) ||
				(unit_ch.valid === 1'b1 && unit_ch.ready === 1'b1)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles = quiet_cycles + 1;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
					$display("simulation failed");
					$finish;
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off counted here when a test asks for one.
	always @(posedge clk) begin
		if (stall_request) begin
			stall_left = HOLD_OFF_CYCLES;
			stall_request = 1'b0;
		end
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			unit_ch.ready <= 1'b0;
		end else begin
			unit_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Offer one byte, with a random gap in front, and hold it until the request is taken.
	// Valid stays high on return so back-to-back bytes never drop it within a step.
	task automatic send_byte(input logic [7:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.text_byte <= b;
		do
			@(posedge clk);
		while (byte_ch.ready !== 1'b1);
		bytes_sent = bytes_sent + 1;
	endtask

	task automatic send_text_buf();
		foreach (text_buf[i])
			send_byte(text_buf[i]);
	endtask

	task automatic stop_sending();
		byte_ch.valid <= 1'b0;
	endtask

	// Let the monitor see the last request, then wait for every expected unit,
	// then long enough for a byte that closes no unit.
	task automatic wait_until_drained();
		@(posedge clk);
		while (expected_units.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_window_reg(input logic index, input logic [15:0] value);
		stop_sending();
		wait_until_drained();
		wr_en    <= 1'b1;
		wr_index <= index;
		wr_data  <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		if (index == REG_WINDOW_START)
			win_start = value;
		else
			win_length = value;
	endtask

	// Append one unit of random content; mostly well-formed, some raw noise.
	task automatic append_random_unit();
		int kind;
		int fin;
		kind = $urandom_range(99);
		if (kind < 35) begin
			text_buf.push_back(rand_byte(8'h20, 8'h7E));
		end else if (kind < 50) begin
			text_buf.push_back(LEAD_2 | rand_byte(0, PAY_2));
			text_buf.push_back(CONT_MARK | rand_byte(0, CONT_BITS));
		end else if (kind < 60) begin
			text_buf.push_back(LEAD_3 | rand_byte(0, PAY_3));
			repeat (2) text_buf.push_back(CONT_MARK | rand_byte(0, CONT_BITS));
		end else if (kind < 66) begin
			text_buf.push_back(LEAD_4 | rand_byte(0, PAY_4));
			repeat (3) text_buf.push_back(CONT_MARK | rand_byte(0, CONT_BITS));
		end else if (kind < 80) begin
			// control sequence; the next unit becomes its visible character
			text_buf.push_back(ESC_BYTE);
			text_buf.push_back(CSI_OPEN);
			repeat ($urandom_range(4))
				text_buf.push_back($urandom_range(3) == 0 ? SEMI_BYTE :
					rand_byte(DIGIT_0, DIGIT_9));
			fin = $urandom_range(9);
			if (fin < 7) begin
				text_buf.push_back(rand_byte(8'h40, 8'h7E));
			end else if (fin == 7) begin
				text_buf.push_back(LEAD_2 | rand_byte(0, PAY_2));
				text_buf.push_back(CONT_MARK | rand_byte(0, CONT_BITS));
			end else if (fin == 8) begin
				text_buf.push_back(ESC_BYTE);
			end else begin
				text_buf.push_back(rand_byte(1, 255));
			end
		end else if (kind < 85) begin
			text_buf.push_back(ESC_BYTE);
		end else if (kind < 90) begin
			text_buf.push_back($urandom_range(1) ? rand_byte(8'h80, 8'hBF) :
				rand_byte(8'hF8, 8'hFF));
		end else begin
			text_buf.push_back(rand_byte(1, 255));
		end
	endtask

	task automatic send_random_string();
		int units;
		int tail;
		text_buf = {};
		units = $urandom_range(10);
		if ($urandom_range(9) == 0) begin
			repeat (units) text_buf.push_back(rand_byte(1, 255));
		end else begin
			repeat (units) append_random_unit();
		end
		// sometimes cut the string off inside a character or a sequence
		if ($urandom_range(9) == 0) begin
			tail = $urandom_range(3);
			if (tail == 0) begin
				text_buf.push_back(LEAD_2 | rand_byte(0, PAY_2));
			end else if (tail == 1) begin
				text_buf.push_back(LEAD_3 | rand_byte(0, PAY_3));
				text_buf.push_back(CONT_MARK | rand_byte(0, CONT_BITS));
			end else if (tail == 2) begin
				text_buf.push_back(LEAD_4 | rand_byte(0, PAY_4));
				repeat ($urandom_range(2))
					text_buf.push_back(CONT_MARK | rand_byte(0, CONT_BITS));
			end else begin
				text_buf.push_back(ESC_BYTE);
				text_buf.push_back(CSI_OPEN);
				text_buf.push_back(rand_byte(DIGIT_0, DIGIT_9));
			end
		end
		text_buf.push_back(NUL_BYTE);
		send_text_buf();
	endtask

	// ASCII and well-formed characters of every length, at the ends of their ranges.
	task automatic test_char_lengths();
		text_buf = '{8'h41, 8'h7F, 8'h01,
			8'hC2, 8'hA9, 8'hDF, 8'hBF,
			8'hE2, 8'h82, 8'hAC, 8'hEF, 8'hBF, 8'hBF,
			8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF7, 8'hBF, 8'hBF, 8'hBF,
			NUL_BYTE};
		send_text_buf();
	endtask

	// Invalid leads, unchecked continuation bytes and an overlong ESC.
	task automatic test_invalid_and_loose_bytes();
		text_buf = '{8'h80, 8'hBF, 8'hF8, 8'hFF,
			8'hE2, 8'h41, 8'h42,
			8'hC0, 8'h9B, 8'h41,
			NUL_BYTE};
		send_text_buf();
	endtask

	// ESC without bracket, plain sequence, multibyte final, ESC as final, doubled ESC.
	task automatic test_escape_sequences();
		text_buf = '{ESC_BYTE, 8'h78,
			ESC_BYTE, CSI_OPEN, 8'h33, 8'h31, SEMI_BYTE, 8'h34, 8'h6D, 8'h41,
			ESC_BYTE, CSI_OPEN, 8'h32, 8'hC3, 8'hA9, 8'h42,
			ESC_BYTE, CSI_OPEN, ESC_BYTE, 8'h43,
			ESC_BYTE, ESC_BYTE, 8'hC3, 8'hA9,
			NUL_BYTE};
		send_text_buf();
	endtask

	// Strings that end with bytes pending (cut characters, open sequences, lone ESC), an empty one and a plain one.
	task automatic test_truncated_ends();
		text_buf = '{8'hC3, NUL_BYTE,
			8'hE2, 8'h82, NUL_BYTE,
			8'hF0, NUL_BYTE,
			8'h41, ESC_BYTE, NUL_BYTE,
			ESC_BYTE, CSI_OPEN, 8'h31, NUL_BYTE,
			ESC_BYTE, CSI_OPEN, 8'hC3, NUL_BYTE,
			ESC_BYTE, CSI_OPEN, 8'h6D, NUL_BYTE,
			NUL_BYTE,
			8'h41, NUL_BYTE};
		send_text_buf();
	endtask

	// A sequence long enough to push the unit byte count past its top.
	task automatic test_byte_count_saturation();
		text_buf = '{ESC_BYTE, CSI_OPEN};
		repeat (260)
			text_buf.push_back($urandom_range(4) == 0 ? SEMI_BYTE : rand_byte(DIGIT_0, DIGIT_9));
		text_buf.push_back(8'h6D);
		text_buf.push_back(8'h41);
		text_buf.push_back(NUL_BYTE);
		send_text_buf();
	endtask

	task automatic window_pass(input logic [15:0] start_idx, input logic [15:0] len);
		write_window_reg(REG_WINDOW_START, start_idx);
		write_window_reg(REG_WINDOW_LENGTH, len);
		text_buf = '{8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, NUL_BYTE};
		send_text_buf();
	endtask

	// Walk the window through empty, narrow, open-ended and top-of-range settings.
	task automatic test_window_settings();
		window_pass(16'd0, 16'd0);
		window_pass(16'd2, 16'd3);
		window_pass(16'hFFFF, 16'hFFFF);
		window_pass(16'd0, 16'd1);
		window_pass(16'd6, 16'hFFFF);
		window_pass(16'hFFFF, 16'd1);
		window_pass(16'd0, 16'hFFFF);
	endtask

	// Hold the receiver off while the sender keeps offering bytes, some of them
	// closing two units, until the result queue fills and input stalls.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_request = 1'b1;
		text_buf = {};
		repeat (6) begin
			text_buf.push_back(8'h41);
			text_buf.push_back(ESC_BYTE);
			text_buf.push_back(8'h78);
			text_buf.push_back(8'hC3);
			text_buf.push_back(8'hA9);
		end
		text_buf.push_back(NUL_BYTE);
		send_text_buf();
	endtask

	// Random strings under one idling mix; retune the window now and then.
	task automatic run_random_phase(input int sender_pct, input int receiver_pct);
		int target;
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		target = bytes_sent + PHASE_ITEMS;
		while (bytes_sent < target) begin
			if ($urandom_range(7) == 0) begin
				write_window_reg(REG_WINDOW_START, 16'($urandom_range(8)));
				write_window_reg(REG_WINDOW_LENGTH, $urandom_range(2) == 0 ? 16'hFFFF :
					16'($urandom_range(8)));
			end
			send_random_string();
		end
	endtask

	initial begin
		byte_ch.valid     = 1'b0;
		byte_ch.text_byte = 8'd0;
		unit_ch.ready     = 1'b0;
		clear_segment_state();
		win_start  = 16'd0;
		win_length = 16'hFFFF;

		// hold reset, then release it at an edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 34;
		recv_idle_pct = 86;
		test_char_lengths();
		test_invalid_and_loose_bytes();
		test_escape_sequences();
		test_truncated_ends();
		test_byte_count_saturation();
		test_window_settings();
		test_backpressure();

		run_random_phase(34, 86);
		run_random_phase(86, 34);
		run_random_phase(0, 0);

		// drop valid, let every expected unit arrive, then wait out the drain margin
		stop_sending();
		wait_until_drained();
		if (error_count == 0 && expected_units.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
